// ----- hdl/all_pairs_circle_overlap_resolve_assert.svh -----
// Assertion macros for the circle overlap resolver
`ifndef ALL_PAIRS_CIRCLE_OVERLAP_RESOLVE_ASSERT_SVH
`define ALL_PAIRS_CIRCLE_OVERLAP_RESOLVE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define APCOR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define APCOR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/apcor_pkg.sv -----
`timescale 1ns / 1ps
package apcor_pkg;

  localparam int unsigned MaxCircles = 64;
  localparam int unsigned IdxW       = $clog2(MaxCircles);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned PosW       = 24;
  localparam int unsigned RadW       = 16;
  localparam int unsigned OutIdxW    = 6;
  // Square of a 25-bit difference summed twice fits in 50 bits
  localparam int unsigned SqW        = 50;
  localparam int unsigned RootW      = 25;
  // Numerator |d| * delta: 25 + 17 bits
  localparam int unsigned NumW       = 42;
  localparam int unsigned DenW       = 27;

  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [RadW-1:0]        radius;
    logic                   last_particle;
  } in_beat_t;

  typedef struct packed {
    logic signed [PosW-1:0] out_x;
    logic signed [PosW-1:0] out_y;
    logic [OutIdxW-1:0]     out_index;
    logic                   out_last;
  } out_beat_t;

  // Control between sequencer and the shared bit-serial unit
  typedef struct packed {
    logic start_sqrt;
    logic start_div;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- hdl/apcor_serial_unit.sv -----
`timescale 1ns / 1ps
// Shared bit-serial unit: restoring square root (one result bit a cycle)
// and restoring division (one quotient bit a cycle).
module apcor_serial_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  apcor_pkg::unit_cmd_t                cmd_i,
  input  logic [apcor_pkg::SqW-1:0]           rad_i,
  input  logic [apcor_pkg::NumW-1:0]          num_i,
  input  logic [apcor_pkg::DenW-1:0]          den_i,
  output apcor_pkg::unit_sts_t                sts_o,
  output logic [apcor_pkg::RootW-1:0]         root_o,
  output logic [apcor_pkg::NumW-1:0]          quot_o
);

  localparam int unsigned StepW = $clog2(apcor_pkg::NumW + 1);

  logic                             mode_q, mode_d;
  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [StepW-1:0]                 step_q, step_d;
  logic [apcor_pkg::SqW-1:0]        shv_q, shv_d;
  logic [apcor_pkg::RootW+1:0]      rem_q, rem_d;
  logic [apcor_pkg::RootW-1:0]      root_q, root_d;
  logic [apcor_pkg::NumW-1:0]       quo_q, quo_d;
  logic [apcor_pkg::DenW:0]         drem_q, drem_d;
  logic [apcor_pkg::DenW-1:0]       den_q, den_d;

  logic [apcor_pkg::RootW+1:0]      trial;
  logic [apcor_pkg::RootW+1:0]      test_s;
  logic [apcor_pkg::DenW:0]         dshift;

  always_comb begin
    mode_d = mode_q;
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    shv_d  = shv_q;
    rem_d  = rem_q;
    root_d = root_q;
    quo_d  = quo_q;
    drem_d = drem_q;
    den_d  = den_q;
    trial  = '0;
    test_s = '0;
    dshift = '0;
    if (cmd_i.start_sqrt) begin
      mode_d = 1'b0;
      busy_d = 1'b1;
      step_d = StepW'(apcor_pkg::RootW);
      shv_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (cmd_i.start_div) begin
      mode_d = 1'b1;
      busy_d = 1'b1;
      step_d = StepW'(apcor_pkg::NumW);
      quo_d  = num_i;
      drem_d = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!mode_q) begin
        // Bring down two radicand bits, try root*4+1
        trial  = {rem_q[apcor_pkg::RootW-1:0], shv_q[apcor_pkg::SqW-1 -: 2]};
        test_s = {root_q, 2'b01};
        shv_d  = {shv_q[apcor_pkg::SqW-3:0], 2'b00};
        if (trial >= test_s) begin
          rem_d  = trial - test_s;
          root_d = {root_q[apcor_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_d  = trial;
          root_d = {root_q[apcor_pkg::RootW-2:0], 1'b0};
        end
      end else begin
        dshift = {drem_q[apcor_pkg::DenW-1:0], quo_q[apcor_pkg::NumW-1]};
        if (dshift >= {1'b0, den_q}) begin
          drem_d = dshift - {1'b0, den_q};
          quo_d  = {quo_q[apcor_pkg::NumW-2:0], 1'b1};
        end else begin
          drem_d = dshift;
          quo_d  = {quo_q[apcor_pkg::NumW-2:0], 1'b0};
        end
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      mode_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shv_q  <= shv_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    quo_q  <= quo_d;
    drem_q <= drem_d;
    den_q  <= den_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;
  assign quot_o     = quo_q;

endmodule

// ----- hdl/all_pairs_circle_overlap_resolve.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Payload            | Handshake
// in      | input     | apcor_pkg::in_beat_t  | in_valid_i / in_ready_o
// out     | output    | apcor_pkg::out_beat_t | out_valid_o / out_ready_i
//
// Loading takes one cycle a beat. After the last beat every pair is visited
// through one shared bit-serial unit: a square root for each pair, then an x
// and a y division only for an overlapping pair. Output reads each circle from
// the position memories and then registers it as its output beat.
// Reset clears control state; stored circles are not cleared.
// A stalled output holds its beat; input is refused during resolve and drain.
module all_pairs_circle_overlap_resolve (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  apcor_pkg::in_beat_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output apcor_pkg::out_beat_t  out_data_o
);

  localparam int unsigned IdxW = apcor_pkg::IdxW;
  localparam int unsigned CntW = apcor_pkg::CntW;
  localparam int unsigned PosW = apcor_pkg::PosW;
  localparam int unsigned RadW = apcor_pkg::RadW;

  localparam logic [3:0] StLoad  = 4'd0;
  localparam logic [3:0] StRdA   = 4'd1;
  localparam logic [3:0] StRdB   = 4'd2;
  localparam logic [3:0] StDiff  = 4'd3;
  localparam logic [3:0] StSq    = 4'd4;
  localparam logic [3:0] StSqrt  = 4'd5;
  localparam logic [3:0] StDivX  = 4'd6;
  localparam logic [3:0] StDivY  = 4'd7;
  localparam logic [3:0] StWrA   = 4'd8;
  localparam logic [3:0] StWrB   = 4'd9;
  localparam logic [3:0] StNext  = 4'd10;
  localparam logic [3:0] StOutRd = 4'd11;
  localparam logic [3:0] StOut   = 4'd12;
  localparam logic [3:0] StMul   = 4'd13;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] ia_q, ia_d, ib_q, ib_d;

  logic signed [PosW-1:0] xmem [apcor_pkg::MaxCircles];
  logic signed [PosW-1:0] ymem [apcor_pkg::MaxCircles];
  logic [RadW-1:0]        rmem [apcor_pkg::MaxCircles];

  logic                   we;
  logic [IdxW-1:0]        waddr, raddr;
  logic signed [PosW-1:0] wx, wy;
  logic                   wr_r;
  logic signed [PosW-1:0] rx_q, ry_q;
  logic [RadW-1:0]        rr_q;

  logic signed [PosW-1:0] xa_q, ya_q;
  logic [RadW-1:0]        ra_q;
  logic signed [PosW:0]   dx_q, dy_q;
  logic [RadW:0]          rsum_q;
  logic [apcor_pkg::SqW-1:0] sq_q, sqy_q;
  logic [apcor_pkg::RootW-1:0] dist_q;
  logic [RadW:0]          delta_q;
  logic [apcor_pkg::NumW-1:0] num_q, qx_q;
  logic signed [PosW-1:0] nxa_q, nya_q, nxb_q, nyb_q;

  logic                   out_valid_q;
  apcor_pkg::out_beat_t   out_q;

  apcor_pkg::unit_cmd_t   cmd;
  apcor_pkg::unit_sts_t   sts;
  logic [apcor_pkg::RootW-1:0] root;
  logic [apcor_pkg::NumW-1:0]  quot;
  logic [apcor_pkg::NumW-1:0]  num_sel;

  logic in_fire, out_fire, last_pair;
  logic signed [apcor_pkg::NumW:0] ox_s, oy_s;

  apcor_serial_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rad_i  (sq_q),
    .num_i  (num_sel),
    .den_i  (apcor_pkg::DenW'({dist_q, 1'b0})),
    .sts_o  (sts),
    .root_o (root),
    .quot_o (quot)
  );

  function automatic logic signed [PosW-1:0] sat_add(
    input logic signed [PosW-1:0] base,
    input logic signed [apcor_pkg::NumW:0] off
  );
    logic signed [apcor_pkg::NumW+1:0] s;
    begin
      s = (apcor_pkg::NumW+2)'(base) + (apcor_pkg::NumW+2)'(off);
      if (s > (apcor_pkg::NumW+2)'(apcor_pkg::PosMax)) return apcor_pkg::PosMax;
      else if (s < (apcor_pkg::NumW+2)'(apcor_pkg::PosMin)) return apcor_pkg::PosMin;
      else return s[PosW-1:0];
    end
  endfunction

  function automatic logic [apcor_pkg::NumW-1:0] abs_d(input logic signed [PosW:0] d);
    logic [PosW:0] m;
    begin
      m = d[PosW] ? (PosW+1)'(-d) : d;
      return apcor_pkg::NumW'(m);
    end
  endfunction

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == StLoad);
  assign last_pair = (ib_q == IdxW'(count_q - 1'b1));
  assign ox_s = dx_q[PosW] ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
  assign oy_s = dy_q[PosW] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign num_sel = num_q;

  // Memory port
  always_ff @(posedge clk_i) begin
    if (we) begin
      xmem[waddr] <= wx;
      ymem[waddr] <= wy;
      if (wr_r) rmem[waddr] <= in_data_i.radius;
    end
    rx_q <= xmem[raddr];
    ry_q <= ymem[raddr];
    rr_q <= rmem[raddr];
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    we      = 1'b0;
    wr_r    = 1'b0;
    waddr   = ia_q;
    raddr   = ia_q;
    wx      = nxa_q;
    wy      = nya_q;
    cmd     = '0;
    unique case (state_q)
      StLoad: begin
        waddr = count_q[IdxW-1:0];
        wx    = in_data_i.pos_x;
        wy    = in_data_i.pos_y;
        if (in_fire) begin
          if (count_q < CntW'(apcor_pkg::MaxCircles)) begin
            we      = 1'b1;
            wr_r    = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (in_data_i.last_particle) begin
            ia_d = '0;
            ib_d = IdxW'(1);
            // A lone circle has no pairs
            if (count_q == '0) state_d = StOutRd;
            else state_d = StRdA;
          end
        end
      end
      StRdA: begin
        raddr   = ia_q;
        state_d = StRdB;
      end
      StRdB: begin
        raddr   = ib_q;
        state_d = StDiff;
      end
      StDiff:  state_d = StMul;
      StMul:   state_d = StSq;
      StSq:    state_d = StSqrt;
      StSqrt: begin
        if (!sts.busy && !sts.done) cmd.start_sqrt = 1'b1;
        else if (sts.done) begin
          if (root == '0 || (RadW+1)'(root) >= rsum_q || root >= apcor_pkg::RootW'(rsum_q))
            state_d = StNext;
          else
            state_d = StDivX;
        end
      end
      StDivX: begin
        if (!sts.busy && !sts.done) cmd.start_div = 1'b1;
        else if (sts.done) state_d = StDivY;
      end
      StDivY: begin
        if (!sts.busy && !sts.done) cmd.start_div = 1'b1;
        else if (sts.done) state_d = StWrA;
      end
      StWrA: begin
        we      = 1'b1;
        waddr   = ia_q;
        wx      = nxa_q;
        wy      = nya_q;
        state_d = StWrB;
      end
      StWrB: begin
        we      = 1'b1;
        waddr   = ib_q;
        wx      = nxb_q;
        wy      = nyb_q;
        state_d = StNext;
      end
      StNext: begin
        if (!last_pair) begin
          ib_d    = ib_q + 1'b1;
          state_d = StRdA;
        end else if (ia_q == IdxW'(count_q - 2'd2)) begin
          ia_d    = '0;
          state_d = StOutRd;
        end else begin
          ia_d    = ia_q + 1'b1;
          ib_d    = ia_q + 2'd2;
          state_d = StRdA;
        end
      end
      StOutRd: begin
        raddr = ia_q;
        if (!out_valid_q || out_ready_i) state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          if (ia_q == IdxW'(count_q - 1'b1)) begin
            count_d = '0;
            state_d = StLoad;
          end else begin
            ia_d    = ia_q + 1'b1;
            state_d = StOutRd;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ia_q    <= ia_d;
      ib_q    <= ib_d;
      if (state_q == StOut && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StRdB: begin
        xa_q <= rx_q;
        ya_q <= ry_q;
        ra_q <= rr_q;
      end
      StDiff: begin
        dx_q   <= (PosW+1)'(xa_q) - (PosW+1)'(rx_q);
        dy_q   <= (PosW+1)'(ya_q) - (PosW+1)'(ry_q);
        rsum_q <= (RadW+1)'(ra_q) + (RadW+1)'(rr_q);
        nxb_q  <= rx_q;
        nyb_q  <= ry_q;
      end
      StMul: begin
        sq_q  <= apcor_pkg::SqW'(abs_d(dx_q)) * apcor_pkg::SqW'(abs_d(dx_q));
        sqy_q <= apcor_pkg::SqW'(abs_d(dy_q)) * apcor_pkg::SqW'(abs_d(dy_q));
      end
      StSq: sq_q <= sq_q + sqy_q;
      StSqrt: begin
        dist_q  <= root;
        delta_q <= rsum_q - (RadW+1)'(root);
        num_q   <= apcor_pkg::NumW'(abs_d(dx_q) * apcor_pkg::NumW'(rsum_q - (RadW+1)'(root)));
      end
      StDivX: begin
        if (sts.done) begin
          qx_q  <= quot;
          num_q <= apcor_pkg::NumW'(abs_d(dy_q) * apcor_pkg::NumW'(delta_q));
        end
      end
      StDivY: begin
        if (sts.done) begin
          nxa_q <= sat_add(xa_q, ox_s);
          nya_q <= sat_add(ya_q, oy_s);
          nxb_q <= sat_add(nxb_q, -ox_s);
          nyb_q <= sat_add(nyb_q, -oy_s);
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.out_x     <= rx_q;
          out_q.out_y     <= ry_q;
          out_q.out_index <= apcor_pkg::OutIdxW'(ia_q);
          out_q.out_last  <= (ia_q == IdxW'(count_q - 1'b1));
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "all_pairs_circle_overlap_resolve_assert.svh"

  `APCOR_ASSERT_IMP(a_no_in_while_busy, state_q != StLoad, !in_ready_o, "input taken while busy")
  `APCOR_ASSERT_IMP(a_pair_order, state_q == StRdA, ia_q < ib_q, "pair indices out of order")
  `APCOR_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o),
                    "stalled beat changed")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int LatencyWait = 300;

  class overlap_scoreboard;
    int                   xs[apcor_pkg::MaxCircles];
    int                   ys[apcor_pkg::MaxCircles];
    int                   rs[apcor_pkg::MaxCircles];
    int                   count;
    apcor_pkg::out_beat_t pending[$];
    int                   mismatches;
    int                   checked;

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function int sat(longint v);
      if (v > longint'(apcor_pkg::PosMax)) return int'(apcor_pkg::PosMax);
      if (v < longint'(apcor_pkg::PosMin)) return int'(apcor_pkg::PosMin);
      return int'(v);
    endfunction

    function void push_apart(int a, int b);
      longint dx, dy, dlen, rsum, delta, ox, oy;
      longint unsigned d2;
      dx = longint'(xs[a]) - longint'(xs[b]);
      dy = longint'(ys[a]) - longint'(ys[b]);
      d2 = dx * dx + dy * dy;
      dlen = longint'(isqrt(d2));
      rsum = longint'(rs[a]) + longint'(rs[b]);
      if (dlen == 0 || dlen >= rsum) return;
      delta = rsum - dlen;
      ox = (dx * delta) / (2 * dlen);
      oy = (dy * delta) / (2 * dlen);
      xs[a] = sat(longint'(xs[a]) + ox);
      ys[a] = sat(longint'(ys[a]) + oy);
      xs[b] = sat(longint'(xs[b]) - ox);
      ys[b] = sat(longint'(ys[b]) - oy);
    endfunction

    function void note_circle(apcor_pkg::in_beat_t b);
      apcor_pkg::out_beat_t e;
      if (count < apcor_pkg::MaxCircles) begin
        xs[count] = int'(b.pos_x);
        ys[count] = int'(b.pos_y);
        rs[count] = int'({16'd0, b.radius});
        count++;
      end
      if (!b.last_particle) return;
      for (int i = 0; i < count; i++)
        for (int j = i + 1; j < count; j++) push_apart(i, j);
      for (int i = 0; i < count; i++) begin
        e.out_x = xs[i][apcor_pkg::PosW-1:0];
        e.out_y = ys[i][apcor_pkg::PosW-1:0];
        e.out_index = i[apcor_pkg::OutIdxW-1:0];
        e.out_last = (i + 1 == count);
        pending.push_back(e);
      end
      count = 0;
    endfunction

    function void check_result(apcor_pkg::out_beat_t got);
      apcor_pkg::out_beat_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat x=%0d y=%0d idx=%0d last=%0b",
                                       got.out_x, got.out_y, got.out_index, got.out_last);
        return;
      end
      e = pending.pop_front();
      if (got.out_x !== e.out_x || got.out_y !== e.out_y ||
          got.out_index !== e.out_index || got.out_last !== e.out_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%0d y=%0d idx=%0d last=%0b, got x=%0d y=%0d idx=%0d last=%0b",
                   e.out_x, e.out_y, e.out_index, e.out_last,
                   got.out_x, got.out_y, got.out_index, got.out_last);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  apcor_pkg::in_beat_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  apcor_pkg::out_beat_t out_data_o;

  overlap_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int items_sent = 0;
  int sets_sent = 0;

  all_pairs_circle_overlap_resolve uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 6000;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  function automatic apcor_pkg::in_beat_t mk_circle(int x, int y, int r, bit last);
    apcor_pkg::in_beat_t b;
    b.pos_x = x[apcor_pkg::PosW-1:0];
    b.pos_y = y[apcor_pkg::PosW-1:0];
    b.radius = r[apcor_pkg::RadW-1:0];
    b.last_particle = last;
    return b;
  endfunction

  // Entered and left at a falling edge
  task automatic send_beat(apcor_pkg::in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i <= apcor_pkg::in_beat_t'($bits(apcor_pkg::in_beat_t)'({$urandom, $urandom,
                                                                       $urandom}));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_circle(b);
    items_sent++;
    if (b.last_particle) sets_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LatencyWait) @(negedge clk_i);
  endtask

  // Clustered set: centres close together so many pairs overlap
  task automatic send_cluster(int n);
    int cx, cy, r, spread;
    cx = $signed($urandom) >>> 9;
    cy = $signed($urandom) >>> 9;
    spread = $urandom_range(1, 4) << ($urandom_range(4, 12));
    for (int i = 0; i < n; i++) begin
      r = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, spread);
      send_beat(mk_circle(cx + $urandom_range(0, 2 * spread) - spread,
                          cy + $urandom_range(0, 2 * spread) - spread, r, i == n - 1));
    end
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++)
      send_beat(mk_circle($urandom, $urandom, $urandom, i == n - 1));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: simple overlap, coincident centres, saturation, radius extremes
    send_beat(mk_circle(0, 0, 'h200, 0));
    send_beat(mk_circle('h100, 0, 'h200, 1));
    send_beat(mk_circle(1000, -1000, 'h300, 0));
    send_beat(mk_circle(1000, -1000, 'h300, 1));
    send_beat(mk_circle(int'(apcor_pkg::PosMax), int'(apcor_pkg::PosMax), 'hFFFF, 0));
    send_beat(mk_circle(int'(apcor_pkg::PosMax) - 'h10, int'(apcor_pkg::PosMax) - 'h8,
                        'hFFFF, 1));
    send_beat(mk_circle(int'(apcor_pkg::PosMin), int'(apcor_pkg::PosMin), 'hFFFF, 0));
    send_beat(mk_circle(int'(apcor_pkg::PosMin) + 1, int'(apcor_pkg::PosMin), 'hFFFF, 1));
    send_beat(mk_circle(5, 5, 0, 0));
    send_beat(mk_circle(6, 5, 0, 1));
    send_beat(mk_circle(-77, 123, 'h40, 1));
    send_beat(mk_circle(0, 0, 'hFFFF, 0));
    send_beat(mk_circle(1, -1, 'h1, 0));
    send_beat(mk_circle(-1, 1, 'h8000, 1));
    send_beat(mk_circle(int'(apcor_pkg::PosMax), int'(apcor_pkg::PosMin), 'hFFFF, 0));
    send_beat(mk_circle(int'(apcor_pkg::PosMin), int'(apcor_pkg::PosMax), 'hFFFF, 1));
    drain();

    // Full set, then one that overflows the store
    send_cluster(apcor_pkg::MaxCircles);
    drain();
    send_cluster(apcor_pkg::MaxCircles + 2);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      if (phase == 2) begin
        // Hold the output off while sets keep coming
        hold_req = 1'b1;
        send_cluster(6);
        send_cluster(5);
        send_cluster(4);
      end
      while (items_sent < 150 + 80 * (phase + 1)) begin
        if ($urandom_range(4) == 0) send_noise($urandom_range(1, 4));
        else send_cluster($urandom_range(2, 8));
      end
      drain();
    end

    $display("ran %0d circles in %0d sets, %0d result beats checked",
             items_sent, sets_sent, sb.checked);
    $display("covered overlap, coincident centres, saturation, overflow and stalls");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/apcor_pkg.sv
hdl/apcor_serial_unit.sv
hdl/all_pairs_circle_overlap_resolve.sv
verif/tb.sv
